// ----- hw/rtl/obbsat_pkg.sv -----
// Shared constants for the oriented-box separating axis test.
package obbsat_pkg;

   // Every request field packs one vector: x in the upper word, y in the lower.
   localparam int FIELD_WIDTH = 64;
   localparam int FIELD_X_LSB = 32;

   // Cycles from the accepting edge of start to the edge that takes rsp_valid.
   localparam int RSP_LATENCY = 6;

   // Axes tested per request and corner half-vectors per request.
   localparam int NUM_AXES    = 4;
   localparam int NUM_CORNERS = 4;

endpackage

// ----- hw/rtl/obb2d_overlap_separating_axis.sv -----
// Top level: pipelined 2D oriented-box overlap test on four separating axes.
//
// Usage:
//  - Request channel: drive start high with all req_* fields for one cycle;
//    the request is taken at that rising edge when busy is low. busy never
//    rises in this design, so a new box pair can enter on every cycle.
//  - Response channel: rsp_valid is high for exactly one cycle, with
//    rsp_overlap = 1 when no axis separates the boxes, 0 when one does.
//    Responses come back in request order, one per request.
//  - Throughput: one request per cycle, set by the fully pipelined
//    dot-product array (20 dot units, 40 multipliers).
//  - Pipeline: input/center difference, products, absolute dot sums,
//    per-box radius max, radius sum vs. distance compare, axis reduction.
//  - Reset (synchronous, active high) clears only the valid bits; requests
//    in flight are dropped and no response is produced for them.
//  - The receiver cannot stall; responses are never held back.
//  - Equality of radius sum and center distance counts as overlap.
module obb2d_overlap_separating_axis
   import obbsat_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [FIELD_WIDTH-1:0] req_center_a,
   input  logic [FIELD_WIDTH-1:0] req_center_b,
   input  logic [FIELD_WIDTH-1:0] req_a_corner_first,
   input  logic [FIELD_WIDTH-1:0] req_a_corner_second,
   input  logic [FIELD_WIDTH-1:0] req_a_axis_first,
   input  logic [FIELD_WIDTH-1:0] req_a_axis_second,
   input  logic [FIELD_WIDTH-1:0] req_b_corner_first,
   input  logic [FIELD_WIDTH-1:0] req_b_corner_second,
   input  logic [FIELD_WIDTH-1:0] req_b_axis_first,
   input  logic [FIELD_WIDTH-1:0] req_b_axis_second,
   output logic                   rsp_valid,
   output logic                   rsp_overlap
);

   localparam int CW       = COORD_WIDTH;
   localparam int DIST_W   = 2 * CW + 2;   // |d . axis|, d has CW+1 bits
   localparam int RAD_W    = 2 * CW + 1;   // |corner . axis|
   localparam int SUM_W    = 2 * CW + 3;   // ra + rb

   logic accept;

   // valid bits for every stage; the top bit is the response strobe
   logic [RSP_LATENCY-1:0] stage_vld_ff, stage_vld_in;

   // stage 1: unpacked coordinates and the exact center difference
   logic signed [CW:0]   d_x_ff, d_x_in;
   logic signed [CW:0]   d_y_ff, d_y_in;
   logic signed [CW-1:0] axis_x_ff   [NUM_AXES];
   logic signed [CW-1:0] axis_y_ff   [NUM_AXES];
   logic signed [CW-1:0] corner_x_ff [NUM_CORNERS];
   logic signed [CW-1:0] corner_y_ff [NUM_CORNERS];
   logic [FIELD_WIDTH-1:0] axis_field   [NUM_AXES];
   logic [FIELD_WIDTH-1:0] corner_field [NUM_CORNERS];

   // stages 2-3 live inside the dot units
   logic [DIST_W-1:0] dist_mag   [NUM_AXES];
   logic [RAD_W-1:0]  corner_mag [NUM_AXES][NUM_CORNERS];

   // stage 4: per-box radius and distance per axis
   logic [DIST_W-1:0] dist_ff [NUM_AXES];
   logic [RAD_W-1:0]  ra_ff   [NUM_AXES], ra_in [NUM_AXES];
   logic [RAD_W-1:0]  rb_ff   [NUM_AXES], rb_in [NUM_AXES];

   // stage 5: separation flag per axis
   logic [NUM_AXES-1:0] sep_ff, sep_in;

   // stage 6: response
   logic rsp_overlap_ff, rsp_overlap_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign stage_vld_in = {stage_vld_ff[RSP_LATENCY-2:0], accept};

   assign axis_field[0]   = req_a_axis_first;
   assign axis_field[1]   = req_a_axis_second;
   assign axis_field[2]   = req_b_axis_first;
   assign axis_field[3]   = req_b_axis_second;
   assign corner_field[0] = req_a_corner_first;
   assign corner_field[1] = req_a_corner_second;
   assign corner_field[2] = req_b_corner_first;
   assign corner_field[3] = req_b_corner_second;

   // d = A - B, one extra bit keeps it exact
   assign d_x_in = {req_center_a[FIELD_X_LSB+CW-1], req_center_a[FIELD_X_LSB +: CW]}
                 - {req_center_b[FIELD_X_LSB+CW-1], req_center_b[FIELD_X_LSB +: CW]};
   assign d_y_in = {req_center_a[CW-1], req_center_a[CW-1:0]}
                 - {req_center_b[CW-1], req_center_b[CW-1:0]};

   always_ff @(posedge clock) begin
      d_x_ff <= d_x_in;
      d_y_ff <= d_y_in;
      for (int i = 0; i < NUM_AXES; i++) begin
         axis_x_ff[i] <= axis_field[i][FIELD_X_LSB +: CW];
         axis_y_ff[i] <= axis_field[i][CW-1:0];
      end
      for (int j = 0; j < NUM_CORNERS; j++) begin
         corner_x_ff[j] <= corner_field[j][FIELD_X_LSB +: CW];
         corner_y_ff[j] <= corner_field[j][CW-1:0];
      end
   end

   // dot-product array: one distance unit and four corner units per axis
   for (genvar gi = 0; gi < NUM_AXES; gi++) begin : g_axis
      obbsat_dot #(
         .U_WIDTH (CW + 1),
         .W_WIDTH (CW)
      ) u_dist (
         .clock (clock),
         .u_x   (d_x_ff),
         .u_y   (d_y_ff),
         .w_x   (axis_x_ff[gi]),
         .w_y   (axis_y_ff[gi]),
         .mag   (dist_mag[gi])
      );
      for (genvar gj = 0; gj < NUM_CORNERS; gj++) begin : g_corner
         obbsat_dot #(
            .U_WIDTH (CW),
            .W_WIDTH (CW)
         ) u_corner (
            .clock (clock),
            .u_x   (corner_x_ff[gj]),
            .u_y   (corner_y_ff[gj]),
            .w_x   (axis_x_ff[gi]),
            .w_y   (axis_y_ff[gi]),
            .mag   (corner_mag[gi][gj])
         );
      end
   end

   // radius of each box: larger of its two corner projections
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         ra_in[i] = (corner_mag[i][0] < corner_mag[i][1]) ? corner_mag[i][1] : corner_mag[i][0];
         rb_in[i] = (corner_mag[i][2] < corner_mag[i][3]) ? corner_mag[i][3] : corner_mag[i][2];
      end
   end

   // separated only when ra + rb is strictly below the distance
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sep_in[i] = (SUM_W'(ra_ff[i]) + SUM_W'(rb_ff[i])) < SUM_W'(dist_ff[i]);
      end
   end

   assign rsp_overlap_in = ~|sep_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_AXES; i++) begin
         dist_ff[i] <= dist_mag[i];
         ra_ff[i]   <= ra_in[i];
         rb_ff[i]   <= rb_in[i];
      end
      sep_ff         <= sep_in;
      rsp_overlap_ff <= rsp_overlap_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   assign rsp_valid   = stage_vld_ff[RSP_LATENCY-1];
   assign rsp_overlap = rsp_overlap_ff;

endmodule

// ----- hw/rtl/obbsat_dot.sv -----
// Two-stage exact absolute dot product of two signed 2D vectors.
module obbsat_dot #(
   parameter int U_WIDTH = 33,
   parameter int W_WIDTH = 32
) (
   input  logic                        clock,
   input  logic signed [U_WIDTH-1:0]   u_x,
   input  logic signed [U_WIDTH-1:0]   u_y,
   input  logic signed [W_WIDTH-1:0]   w_x,
   input  logic signed [W_WIDTH-1:0]   w_y,
   output logic [U_WIDTH+W_WIDTH:0]    mag
);

   localparam int PROD_WIDTH = U_WIDTH + W_WIDTH;

   logic signed [PROD_WIDTH-1:0] prod_x_ff, prod_x_in;
   logic signed [PROD_WIDTH-1:0] prod_y_ff, prod_y_in;
   logic [PROD_WIDTH:0]          sum;
   logic [PROD_WIDTH:0]          mag_ff, mag_in;

   // stage A: the two products, operands sign-extended to the full product width
   assign prod_x_in = PROD_WIDTH'(u_x) * PROD_WIDTH'(w_x);
   assign prod_y_in = PROD_WIDTH'(u_y) * PROD_WIDTH'(w_y);

   // stage B: exact sum, then magnitude (most negative sum fits as unsigned)
   assign sum    = {prod_x_ff[PROD_WIDTH-1], prod_x_ff} + {prod_y_ff[PROD_WIDTH-1], prod_y_ff};
   assign mag_in = sum[PROD_WIDTH] ? (~sum + {{PROD_WIDTH{1'b0}}, 1'b1}) : sum;

   always_ff @(posedge clock) begin
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      mag_ff    <= mag_in;
   end

   assign mag = mag_ff;

endmodule

// ----- hw/rtl/obbsat_checker.sv -----
// Port-level timing checks for the box overlap pipeline, bound to the top level.
module obbsat_checker
   import obbsat_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // every accepted request yields its response a fixed time later
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##RSP_LATENCY rsp_valid)
      else $error("response missing for accepted request");

   // no response without a matching request
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, RSP_LATENCY))
      else $error("response without a request");

   // reset flushes the pipeline
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response right after reset");

endmodule

bind obb2d_overlap_separating_axis obbsat_checker u_obbsat_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

// ----- tb/obb2d_overlap_checker.sv -----
// Checker for the 2D box overlap block: predicts each response and compares it.
module obb2d_overlap_checker
   import obbsat_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [9:0][FIELD_WIDTH-1:0] req_fields,
   input  logic                        rsp_valid,
   input  logic                        rsp_overlap,
   output int                          mismatches,
   output int                          pending,
   output int                          checked,
   output int                          separated
);

   // Slot of each vector in the request bundle.
   localparam int SLOT_CENTER_A = 0;
   localparam int SLOT_CENTER_B = 1;
   localparam int SLOT_A_CORNER = 2;
   localparam int SLOT_A_AXIS   = 4;
   localparam int SLOT_B_CORNER = 6;
   localparam int SLOT_B_AXIS   = 8;

   logic overlap_q[$];
   logic want;

   function automatic logic signed [71:0] sext(input logic [31:0] c);
      return {{40{c[31]}}, c};
   endfunction

   function automatic logic signed [71:0] x_of(input logic [FIELD_WIDTH-1:0] f);
      return sext(f[FIELD_X_LSB +: 32]);
   endfunction

   function automatic logic signed [71:0] y_of(input logic [FIELD_WIDTH-1:0] f);
      return sext(f[31:0]);
   endfunction

   // |p . a|, exact in 72 bits
   function automatic logic [71:0] projection(input logic signed [71:0] px,
                                              input logic signed [71:0] py,
                                              input logic signed [71:0] ax,
                                              input logic signed [71:0] ay);
      logic signed [71:0] s;
      s = px * ax + py * ay;
      return (s < 0) ? -s : s;
   endfunction

   function automatic logic [71:0] box_radius(input logic [FIELD_WIDTH-1:0] c0,
                                              input logic [FIELD_WIDTH-1:0] c1,
                                              input logic signed [71:0] ax,
                                              input logic signed [71:0] ay);
      logic [71:0] r0;
      logic [71:0] r1;
      r0 = projection(x_of(c0), y_of(c0), ax, ay);
      r1 = projection(x_of(c1), y_of(c1), ax, ay);
      return (r0 < r1) ? r1 : r0;
   endfunction

   function automatic logic predict_overlap(input logic [9:0][FIELD_WIDTH-1:0] f);
      logic signed [71:0] dx;
      logic signed [71:0] dy;
      logic signed [71:0] ax;
      logic signed [71:0] ay;
      logic [FIELD_WIDTH-1:0] axis;
      logic [71:0] center_span;
      logic [71:0] reach;
      logic hit;
      dx = x_of(f[SLOT_CENTER_A]) - x_of(f[SLOT_CENTER_B]);
      dy = y_of(f[SLOT_CENTER_A]) - y_of(f[SLOT_CENTER_B]);
      hit = 1'b1;
      for (int i = 0; i < NUM_AXES; i++) begin
         axis = (i < 2) ? f[SLOT_A_AXIS + i] : f[SLOT_B_AXIS + i - 2];
         ax = x_of(axis);
         ay = y_of(axis);
         center_span = projection(dx, dy, ax, ay);
         reach = box_radius(f[SLOT_A_CORNER], f[SLOT_A_CORNER + 1], ax, ay)
               + box_radius(f[SLOT_B_CORNER], f[SLOT_B_CORNER + 1], ax, ay);
         // touching counts as overlap
         if (reach < center_span) hit = 1'b0;
      end
      return hit;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         overlap_q.delete();
         mismatches <= 0;
         pending    <= 0;
         checked    <= 0;
         separated  <= 0;
      end else begin
         if (rsp_valid !== 1'b0) begin
            if (overlap_q.size() == 0) begin
               $display("%0t: unexpected response, expected none actual overlap=%b",
                        $time, rsp_overlap);
               mismatches <= mismatches + 1;
            end else begin
               want = overlap_q.pop_front();
               checked <= checked + 1;
               if (!want) separated <= separated + 1;
               if (rsp_valid !== 1'b1 || rsp_overlap !== want) begin
                  $display("%0t: overlap mismatch, expected %b actual %b (valid %b)",
                           $time, want, rsp_overlap, rsp_valid);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (start && busy === 1'b0) overlap_q.push_back(predict_overlap(req_fields));
         pending <= overlap_q.size();
      end
   end

endmodule

// ----- tb/tb_obb2d_overlap_separating_axis.sv -----
// Testbench top for the 2D oriented-box separating axis block.
module tb_obb2d_overlap_separating_axis
   import obbsat_pkg::*;
();

   localparam int COORD_W  = 32;
   localparam int N_RANDOM = 700;
   localparam int LIMIT    = 60000;
   // One unit in Q16.16.
   localparam logic [31:0] ONE = 32'h0001_0000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic rsp_valid;
   logic rsp_overlap;
   // Request bundle: centers A/B, A corners, A axes, B corners, B axes.
   logic [9:0][FIELD_WIDTH-1:0] req_bus;

   int mismatches;
   int pending;
   int checked;
   int separated;
   int cycle_count;
   int sent;
   int directed;

   obb2d_overlap_separating_axis #(
      .COORD_WIDTH(COORD_W)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_center_a       (req_bus[0]),
      .req_center_b       (req_bus[1]),
      .req_a_corner_first (req_bus[2]),
      .req_a_corner_second(req_bus[3]),
      .req_a_axis_first   (req_bus[4]),
      .req_a_axis_second  (req_bus[5]),
      .req_b_corner_first (req_bus[6]),
      .req_b_corner_second(req_bus[7]),
      .req_b_axis_first   (req_bus[8]),
      .req_b_axis_second  (req_bus[9]),
      .rsp_valid          (rsp_valid),
      .rsp_overlap        (rsp_overlap)
   );

   obb2d_overlap_checker chk (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_fields (req_bus),
      .rsp_valid  (rsp_valid),
      .rsp_overlap(rsp_overlap),
      .mismatches (mismatches),
      .pending    (pending),
      .checked    (checked),
      .separated  (separated)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Pack one vector, x in the upper word.
   function automatic logic [63:0] vec(input logic [31:0] x, input logic [31:0] y);
      return {x, y};
   endfunction

   // Uniform value in [-lim, lim], as a raw coordinate.
   function automatic logic [31:0] spread(input int lim);
      return int'($urandom_range(0, 2 * lim)) - lim;
   endfunction

   // Present a request and hold it until the block takes it. start stays
   // high on return so back-to-back requests never drop it in between.
   task automatic issue(input logic [9:0][FIELD_WIDTH-1:0] pair);
      start   <= 1'b1;
      req_bus <= pair;
      do @(posedge clock); while (busy !== 1'b0);
      sent++;
   endtask

   task automatic go_idle(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off until every outstanding response has been checked.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Axis-aligned square pair, half-width one unit, B offset by (dx, dy) (raw units).
   function automatic logic [9:0][63:0] squares(input logic [31:0] dx,
                                                input logic [31:0] dy,
                                                input logic [31:0] k);
      logic [9:0][63:0] p;
      p[0] = vec(0, 0);
      p[1] = vec(dx, dy);
      p[2] = vec(ONE, ONE);
      p[3] = vec(ONE, -ONE);
      p[4] = vec(k, 0);
      p[5] = vec(0, k);
      p[6] = vec(ONE, ONE);
      p[7] = vec(-ONE, ONE);
      p[8] = vec(k, 0);
      p[9] = vec(0, k);
      return p;
   endfunction

   task automatic run_directed();
      logic [9:0][63:0] p;
      // everything zero: zero axes never separate
      issue('0);
      // all ones: every coordinate is the smallest negative step
      issue({10{64'hFFFF_FFFF_FFFF_FFFF}});
      // touching squares (equality overlaps), one step apart, one step in
      issue(squares(2 * ONE, 0, ONE));
      issue(squares(2 * ONE + 1, 0, ONE));
      issue(squares(2 * ONE - 1, 0, ONE));
      issue(squares(0, -(2 * ONE + 1), ONE));
      issue(squares(-(2 * ONE), 0, ONE));
      // axes not of unit length are used as given
      issue(squares(2 * ONE, 0, 3 * ONE));
      issue(squares(2 * ONE + 1, 0, 3 * ONE));
      issue(squares(0, 2 * ONE + 1, 32'h8000_0000));
      // zero axes with centers at opposite extremes
      p = '0;
      p[0] = vec(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      p[1] = vec(32'h8000_0000, 32'h8000_0000);
      issue(p);
      // widest center distance, degenerate boxes: separated
      p[4] = vec(32'h8000_0000, 32'h8000_0000);
      p[5] = p[4];
      p[8] = p[4];
      p[9] = p[4];
      issue(p);
      // most negative corners: radius sum carries past 64 bits
      p[2] = vec(32'h8000_0000, 32'h8000_0000);
      p[3] = p[2];
      p[6] = p[2];
      p[7] = p[2];
      issue(p);
      // mixed sign extremes on corners and axes
      p[2] = vec(32'h7FFF_FFFF, 32'h8000_0000);
      p[3] = vec(32'h8000_0000, 32'h7FFF_FFFF);
      p[4] = vec(32'h8000_0000, 32'h7FFF_FFFF);
      p[6] = vec(0, 0);
      p[7] = vec(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      p[8] = vec(32'h7FFF_FFFF, 32'h8000_0000);
      issue(p);
      // only B's second axis can separate (others zero)
      p = '0;
      p[1] = vec(0, 5 * ONE);
      p[2] = vec(ONE, ONE);
      p[3] = vec(ONE, -ONE);
      p[6] = vec(ONE, ONE);
      p[7] = vec(ONE, -ONE);
      p[9] = vec(0, ONE);
      issue(p);
      // only B's first axis can separate
      p[1] = vec(-(5 * ONE), 0);
      p[8] = vec(ONE, 0);
      p[9] = vec(0, 0);
      issue(p);
      // second corner gives the radius; touching then apart
      p = '0;
      p[1] = vec(4 * ONE, 0);
      p[2] = vec(ONE, 0);
      p[3] = vec(3 * ONE, 0);
      p[6] = vec(ONE, 0);
      p[4] = vec(ONE, 0);
      issue(p);
      p[1] = vec(4 * ONE + 1, 0);
      issue(p);
      directed = sent;
   endtask

   // Random request: scattered boxes, near-touching aligned boxes, or raw bits.
   function automatic logic [9:0][63:0] random_pair();
      logic [9:0][63:0] p;
      logic [31:0] k;
      logic [31:0] hax;
      logic [31:0] hay;
      logic [31:0] hbx;
      logic [31:0] hby;
      logic [31:0] delta;
      int mode;
      mode = $urandom_range(0, 99);
      if (mode < 40) begin
         p[0] = vec(spread(24 * ONE), spread(24 * ONE));
         p[1] = vec(spread(24 * ONE), spread(24 * ONE));
         for (int i = 2; i < 10; i++) begin
            if (i == 4 || i == 5 || i == 8 || i == 9)
               p[i] = vec(spread(ONE), spread(ONE));
            else
               p[i] = vec(spread(6 * ONE), spread(6 * ONE));
         end
      end else if (mode < 75) begin
         // aligned boxes right at the contact point, give or take one step
         k   = $urandom_range(1, 2 * ONE);
         hax = $urandom_range(0, 4 * ONE);
         hay = $urandom_range(0, 4 * ONE);
         hbx = $urandom_range(0, 4 * ONE);
         hby = $urandom_range(0, 4 * ONE);
         delta = int'($urandom_range(0, 2)) - 1;
         p[0] = vec(spread(8 * ONE), spread(8 * ONE));
         if ($urandom_range(0, 1))
            p[1] = vec(p[0][63:32] - hax - hbx - delta,
                       p[0][31:0] + spread(int'(hay + hby)));
         else
            p[1] = vec(p[0][63:32] + spread(int'(hax + hbx)),
                       p[0][31:0] + hay + hby + delta);
         p[2] = vec(hax, hay);
         p[3] = vec(-hax, hay);
         p[6] = vec(hbx, -hby);
         p[7] = vec(hbx, hby);
         if ($urandom_range(0, 1)) {p[2], p[3]} = {p[3], p[2]};
         p[4] = vec(k, 0);
         p[5] = vec(0, -k);
         p[8] = vec(0, k);
         p[9] = vec(-k, 0);
      end else begin
         for (int i = 0; i < 10; i++) p[i] = {$urandom, $urandom};
      end
      return p;
   endfunction

   // Stimulus: directed cases, then random bursts with random gaps.
   initial begin
      int burst;
      reset   = 1'b1;
      start   = 1'b0;
      req_bus = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      drain();

      burst = 0;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (burst == 0) begin
            // a third of the bursts run straight into the next one
            if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 12));
            burst = $urandom_range(1, 40);
         end
         // one full stop midway: wait out every response
         if (n == N_RANDOM / 2) drain();
         issue(random_pair());
         burst--;
      end

      drain();
      repeat (RSP_LATENCY + 4) @(posedge clock);

      $display("Run: %0d requests (%0d directed), %0d responses checked, %0d separated",
               sent, directed, checked, separated);
      $display("Cases: touching and one-step pairs, extreme coordinates, zero axes, raw bits");
      if (mismatches == 0 && pending == 0)
         $display("tb_obb2d_overlap_separating_axis: PASS");
      else
         $display("tb_obb2d_overlap_separating_axis: FAIL");
      $finish;
   end

   // Watchdog on the cycle counter.
   initial begin
      while (cycle_count < LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
      $display("tb_obb2d_overlap_separating_axis: FAIL");
      $finish;
   end

endmodule
